// ===== src/hpc_pkg.sv =====
`timescale 1ns / 1ps
// hpc_pkg: shared types and constants of the half-plane polygon clipper.
// No dependencies; imported by every module of the block.
package hpc_pkg;

    localparam int COORD_W = 32;
    localparam int NORM_W  = 16;
    localparam int DIST_W  = 40;
    localparam int CNT_W   = 7;
    localparam int T_W     = 16;
    localparam int MUL_A_W = COORD_W + 1;
    localparam int MUL_B_W = T_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ADDR_W  = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] KIND_KEEP  = 2'd0;
    localparam logic [1:0] KIND_CROSS = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [1:0] CFG_NORMAL_X      = 2'd0;
    localparam logic [1:0] CFG_NORMAL_Y      = 2'd1;
    localparam logic [1:0] CFG_PLANE_OFFSET  = 2'd2;
    localparam logic [1:0] CFG_KEEP_OPPOSITE = 2'd3;

    typedef struct packed {
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [COORD_W-1:0] plane_offset;
        logic                      keep_opposite;
    } cfg_t;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_MULX  = 16'h0002,
        ST_MULY  = 16'h0004,
        ST_DSUM  = 16'h0008,
        ST_DNEG  = 16'h0010,
        ST_EDGE  = 16'h0020,
        ST_KEEP  = 16'h0040,
        ST_DIVS  = 16'h0080,
        ST_DIVW  = 16'h0100,
        ST_LMX   = 16'h0200,
        ST_LAX   = 16'h0400,
        ST_LMY   = 16'h0800,
        ST_LAY   = 16'h1000,
        ST_CROSS = 16'h2000,
        ST_ENDM  = 16'h4000,
        ST_DONE  = 16'h8000
    } state_t;

endpackage

// ===== src/hpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// hpc_cfg_regs: APB register file holding the clip plane settings.
// Depends on hpc_pkg (cfg_t, register indexes).
module hpc_cfg_regs
    import hpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                CFG_NORMAL_X:      cfg_next.normal_x      = pwdata[NORM_W-1:0];
                CFG_NORMAL_Y:      cfg_next.normal_y      = pwdata[NORM_W-1:0];
                CFG_PLANE_OFFSET:  cfg_next.plane_offset  = pwdata;
                CFG_KEEP_OPPOSITE: cfg_next.keep_opposite = pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            CFG_NORMAL_X:      prdata = {{(32-NORM_W){cfg_reg.normal_x[NORM_W-1]}},
                                         cfg_reg.normal_x};
            CFG_NORMAL_Y:      prdata = {{(32-NORM_W){cfg_reg.normal_y[NORM_W-1]}},
                                         cfg_reg.normal_y};
            CFG_PLANE_OFFSET:  prdata = cfg_reg.plane_offset;
            CFG_KEEP_OPPOSITE: prdata = {31'd0, cfg_reg.keep_opposite};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_x      <= 16'sd16384;
            cfg_reg.normal_y      <= '0;
            cfg_reg.plane_offset  <= '0;
            cfg_reg.keep_opposite <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/hpc_mul.sv =====
`timescale 1ns / 1ps
// hpc_mul: shared signed multiplier with registered product.
// Depends on hpc_pkg (operand widths).
module hpc_mul
    import hpc_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// ===== src/hpc_div.sv =====
`timescale 1ns / 1ps
// hpc_div: radix-2 restoring divider, one quotient bit per cycle, for the
// crossing ratio t = (num << 16) / den with num < den. Depends on hpc_pkg.
module hpc_div
    import hpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIST_W-1:0] num,
    input  logic [DIST_W-1:0] den,
    output logic [T_W-1:0]    quo,
    output logic              done
);

    localparam int CNT_BITS = $clog2(T_W);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(T_W - 1);

    logic [DIST_W-1:0]   rem_reg, rem_next;
    logic [DIST_W-1:0]   den_reg, den_next;
    logic [T_W-1:0]      quo_reg, quo_next;
    logic [CNT_BITS-1:0] step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIST_W:0]     shifted;
    logic [DIST_W:0]     trial;
    logic                fits;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};
    assign quo     = quo_reg;
    assign done    = done_reg;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            den_next  = den;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[DIST_W-1:0] : shifted[DIST_W-1:0];
            quo_next  = {quo_reg[T_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

// ===== src/polygon_half_plane_clipper_top.sv =====
`timescale 1ns / 1ps
// polygon_half_plane_clipper_top: sequencer and datapath of the clipper.
// Depends on hpc_pkg, hpc_cfg_regs, hpc_mul and hpc_div.
//
// Clips a convex polygon against one half-plane, one vertex per request.
// Each vertex is handled by a sequencer around one shared 33x17 multiplier
// and a one-bit-per-cycle divider; s_ready is low while a vertex is at
// work. A vertex with nothing to emit passes through two multiplies for the
// plane distance, the sum, the sign, the edge test and bookkeeping; the
// first vertex of a polygon skips the edge test. Each kept vertex adds an
// output step, each crossing adds a divider start and its steps, then two
// multiply-add steps for the interpolation and the output step, and a final
// vertex adds its closing edge and the end marker. Any wait on m_ready to
// free the output register adds to this.
module polygon_half_plane_clipper_top
    import hpc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_vertex_x,
    input  logic signed [COORD_W-1:0] s_vertex_y,
    input  logic                      s_final_vertex,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_out_x,
    output logic signed [COORD_W-1:0] m_out_y,
    output logic [1:0]                m_kind,
    output logic [CNT_W-1:0]          m_vertex_count,
    output logic                      m_run_end
);

    cfg_t cfg;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;
    logic   have_first_reg, have_first_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic   m_valid_reg, m_valid_next;

    logic signed [COORD_W-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic                      last_reg, last_next;
    logic signed [DIST_W-1:0]  cur_d_reg, cur_d_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [DIST_W-1:0]  prev_d_reg, prev_d_next;
    logic signed [COORD_W-1:0] first_x_reg, first_x_next;
    logic signed [COORD_W-1:0] first_y_reg, first_y_next;
    logic signed [DIST_W-1:0]  first_d_reg, first_d_next;
    logic signed [PROD_W-1:0]  p1_reg, p1_next;
    logic signed [DIST_W-1:0]  dsum_reg, dsum_next;
    logic [DIST_W-1:0]         ua_reg, ua_next, ub_reg, ub_next;
    logic                      cross_reg, cross_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [1:0]                okind_reg, okind_next;
    logic [CNT_W-1:0]          ocnt_reg, ocnt_next;
    logic                      orun_reg, orun_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      div_go;
    logic [T_W-1:0]            div_quo;
    logic                      div_done;

    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic signed [DIST_W-1:0]  da, db, dneg;
    logic [PROD_W:0]           dist_sum;
    logic [DIST_W-1:0]         dsum_calc;
    logic                      out_free;
    logic [CNT_W-1:0]          cnt_inc;
    state_t                    after_state;
    logic                      after_sel;
    logic                      a_neg, a_pos, b_neg, b_pos;

    hpc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    hpc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    hpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .num     (ua_reg),
        .den     (ua_reg + ub_reg),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign pready         = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_out_x        = ox_reg;
    assign m_out_y        = oy_reg;
    assign m_kind         = okind_reg;
    assign m_vertex_count = ocnt_reg;
    assign m_run_end      = orun_reg;

    // edge operands: prev -> cur, or the closing edge cur -> first
    assign ax = sel_reg ? cur_x_reg   : prev_x_reg;
    assign ay = sel_reg ? cur_y_reg   : prev_y_reg;
    assign da = sel_reg ? cur_d_reg   : prev_d_reg;
    assign bx = sel_reg ? first_x_reg : cur_x_reg;
    assign by = sel_reg ? first_y_reg : cur_y_reg;
    assign db = sel_reg ? first_d_reg : cur_d_reg;

    assign a_neg = da[DIST_W-1];
    assign a_pos = !da[DIST_W-1] && (da != '0);
    assign b_neg = db[DIST_W-1];
    assign b_pos = !db[DIST_W-1] && (db != '0);

    assign dist_sum  = {p1_reg[PROD_W-1], p1_reg} + {mul_prod[PROD_W-1], mul_prod};
    assign dsum_calc = {{(DIST_W-(PROD_W+1-14)){dist_sum[PROD_W]}}, dist_sum[PROD_W:14]}
                     - {{(DIST_W-COORD_W){cfg.plane_offset[COORD_W-1]}}, cfg.plane_offset};
    assign dneg      = cfg.keep_opposite ? -dsum_reg : dsum_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign cnt_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb begin
        if (!sel_reg && last_reg) begin
            after_state = ST_EDGE;
            after_sel   = 1'b1;
        end else if (last_reg) begin
            after_state = ST_ENDM;
            after_sel   = sel_reg;
        end else begin
            after_state = ST_DONE;
            after_sel   = sel_reg;
        end
    end

    always_comb begin
        unique case (state_reg)
            ST_MULX: begin
                mul_a = {cur_x_reg[COORD_W-1], cur_x_reg};
                mul_b = {{(MUL_B_W-NORM_W){cfg.normal_x[NORM_W-1]}}, cfg.normal_x};
            end
            ST_MULY: begin
                mul_a = {cur_y_reg[COORD_W-1], cur_y_reg};
                mul_b = {{(MUL_B_W-NORM_W){cfg.normal_y[NORM_W-1]}}, cfg.normal_y};
            end
            ST_LMX: begin
                mul_a = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
                mul_b = {1'b0, div_quo};
            end
            ST_LMY: begin
                mul_a = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
                mul_b = {1'b0, div_quo};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        have_first_next = have_first_reg;
        count_next      = count_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        last_next       = last_reg;
        cur_d_next      = cur_d_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_d_next     = prev_d_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        first_d_next    = first_d_reg;
        p1_next         = p1_reg;
        dsum_next       = dsum_reg;
        ua_next         = ua_reg;
        ub_next         = ub_reg;
        cross_next      = cross_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        okind_next      = okind_reg;
        ocnt_next       = ocnt_reg;
        orun_next       = orun_reg;
        div_go          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cur_x_next = s_vertex_x;
                    cur_y_next = s_vertex_y;
                    last_next  = s_final_vertex;
                    state_next = ST_MULX;
                end
            end
            ST_MULX: state_next = ST_MULY;
            ST_MULY: begin
                p1_next    = mul_prod;
                state_next = ST_DSUM;
            end
            ST_DSUM: begin
                dsum_next  = dsum_calc;
                state_next = ST_DNEG;
            end
            ST_DNEG: begin
                cur_d_next = dneg;
                if (!have_first_reg) begin
                    first_x_next    = cur_x_reg;
                    first_y_next    = cur_y_reg;
                    first_d_next    = dneg;
                    have_first_next = 1'b1;
                    count_next      = '0;
                end
                if (have_first_reg) begin
                    sel_next   = 1'b0;
                    state_next = ST_EDGE;
                end else if (last_reg) begin
                    sel_next   = 1'b1;
                    state_next = ST_EDGE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EDGE: begin
                ua_next    = a_neg ? -da : da;
                ub_next    = b_neg ? -db : db;
                cross_next = (a_neg && b_pos) || (a_pos && b_neg);
                if (a_neg) begin
                    state_next = ST_KEEP;
                end else if ((a_neg && b_pos) || (a_pos && b_neg)) begin
                    state_next = ST_DIVS;
                end else begin
                    state_next = after_state;
                    sel_next   = after_sel;
                end
            end
            ST_KEEP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ox_next      = ax;
                    oy_next      = ay;
                    okind_next   = KIND_KEEP;
                    ocnt_next    = cnt_inc;
                    orun_next    = !cross_reg && !last_reg;
                    count_next   = cnt_inc;
                    if (cross_reg) begin
                        state_next = ST_DIVS;
                    end else begin
                        state_next = after_state;
                        sel_next   = after_sel;
                    end
                end
            end
            ST_DIVS: begin
                div_go     = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW: begin
                if (div_done) begin
                    state_next = ST_LMX;
                end
            end
            ST_LMX: state_next = ST_LAX;
            ST_LAX: begin
                cx_next    = ax + mul_prod[COORD_W+15:16];
                state_next = ST_LMY;
            end
            ST_LMY: state_next = ST_LAY;
            ST_LAY: begin
                cy_next    = ay + mul_prod[COORD_W+15:16];
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ox_next      = cx_reg;
                    oy_next      = cy_reg;
                    okind_next   = KIND_CROSS;
                    ocnt_next    = cnt_inc;
                    orun_next    = !last_reg;
                    count_next   = cnt_inc;
                    state_next   = after_state;
                    sel_next     = after_sel;
                end
            end
            ST_ENDM: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ox_next      = '0;
                    oy_next      = '0;
                    okind_next   = KIND_END;
                    ocnt_next    = count_reg;
                    orun_next    = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                prev_x_next = cur_x_reg;
                prev_y_next = cur_y_reg;
                prev_d_next = cur_d_reg;
                if (last_reg) begin
                    have_first_next = 1'b0;
                    count_next      = '0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sel_reg        <= 1'b0;
            have_first_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            have_first_reg <= have_first_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        last_reg    <= last_next;
        cur_d_reg   <= cur_d_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        prev_d_reg  <= prev_d_next;
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        first_d_reg <= first_d_next;
        p1_reg      <= p1_next;
        dsum_reg    <= dsum_next;
        ua_reg      <= ua_next;
        ub_reg      <= ub_next;
        cross_reg   <= cross_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        okind_reg   <= okind_next;
        ocnt_reg    <= ocnt_next;
        orun_reg    <= orun_next;
    end

endmodule

// ===== src/hpc_checker.sv =====
`timescale 1ns / 1ps
// hpc_checker: port-level assertions for the clipper, bound to the top.
// Depends on hpc_pkg (kind codes, widths).
module hpc_checker
    import hpc_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [COORD_W-1:0] m_out_x,
    input logic signed [COORD_W-1:0] m_out_y,
    input logic [1:0]                m_kind,
    input logic [CNT_W-1:0]          m_vertex_count,
    input logic                      m_run_end
);

    // a vertex request keeps the sequencer busy, so s_ready drops after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after a request");

    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_END) |-> m_run_end && (m_out_x == '0) && (m_out_y == '0))
        else $error("malformed end marker");

    a_vertex_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_END) |-> (m_vertex_count != '0) && (m_kind != 2'd3))
        else $error("emitted vertex with zero count or bad kind");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_kind) && $stable(m_vertex_count) && $stable(m_run_end))
        else $error("result changed while stalled");

endmodule

bind polygon_half_plane_clipper_top hpc_checker u_hpc_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for polygon_half_plane_clipper_top.
// Depends on hpc_pkg; predicts every clipped vertex and end marker in SV.
module tb;
    import hpc_pkg::*;

    localparam int     ONE         = 65536;
    localparam int     SETTLE      = 16;
    localparam int     CYCLE_LIMIT = 500_000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [1:0]                kind;
        logic [CNT_W-1:0]          count;
        logic                      run_end;
    } clip_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_vertex_x = '0;
    logic signed [COORD_W-1:0] s_vertex_y = '0;
    logic                      s_final_vertex = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_out_x;
    logic signed [COORD_W-1:0] m_out_y;
    logic [1:0]                m_kind;
    logic [CNT_W-1:0]          m_vertex_count;
    logic                      m_run_end;

    // clip plane as the block holds it
    logic signed [NORM_W-1:0]  plane_nx = 16'sd16384;
    logic signed [NORM_W-1:0]  plane_ny = '0;
    logic signed [COORD_W-1:0] plane_off = '0;
    logic                      plane_flip = 1'b0;

    // polygon in progress
    longint                    first_px, first_py, first_dist;
    longint                    prev_px, prev_py, prev_dist;
    bit                        poly_open = 1'b0;
    logic [CNT_W-1:0]          poly_count = '0;

    clip_result_t              clipped_q[$];
    clip_result_t              want;
    int unsigned               mismatches = 0;
    int unsigned               vertices_sent = 0;
    int unsigned               cycle_count = 0;
    int unsigned               send_idle_pct = 20;
    int unsigned               recv_idle_pct = 65;

    polygon_half_plane_clipper_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vertex_x     (s_vertex_x),
        .s_vertex_y     (s_vertex_y),
        .s_final_vertex (s_final_vertex),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_kind         (m_kind),
        .m_vertex_count (m_vertex_count),
        .m_run_end      (m_run_end)
    );

    always #5 aclk = ~aclk;

    function automatic longint plane_distance(longint x, longint y);
        longint d;
        d = ((x * longint'(plane_nx) + y * longint'(plane_ny)) >>> 14) - longint'(plane_off);
        return plane_flip ? -d : d;
    endfunction

    function automatic void emit_vertex(longint x, longint y, logic [1:0] kind);
        clip_result_t r;
        if (kind != KIND_END && poly_count != COUNT_MAX) begin
            poly_count++;
        end
        r.x       = COORD_W'(x);
        r.y       = COORD_W'(y);
        r.kind    = kind;
        r.count   = poly_count;
        r.run_end = 1'b0;
        clipped_q.push_back(r);
    endfunction

    function automatic int clip_edge(longint ax, longint ay, longint da,
                                     longint bx, longint by, longint db);
        int     n;
        longint ua, ub, t;
        n = 0;
        if (da < 0) begin
            emit_vertex(ax, ay, KIND_KEEP);
            n++;
        end
        if ((da < 0 && db > 0) || (da > 0 && db < 0)) begin
            ua = (da < 0) ? -da : da;
            ub = (db < 0) ? -db : db;
            t  = (ua <<< 16) / (ua + ub);
            emit_vertex(ax + (((bx - ax) * t) >>> 16), ay + (((by - ay) * t) >>> 16),
                        KIND_CROSS);
            n++;
        end
        return n;
    endfunction

    function automatic void clip_vertex(longint x, longint y, logic fin);
        longint d;
        int     n;
        d = plane_distance(x, y);
        n = 0;
        if (!poly_open) begin
            first_px   = x;
            first_py   = y;
            first_dist = d;
            poly_open  = 1'b1;
            poly_count = '0;
        end else begin
            n += clip_edge(prev_px, prev_py, prev_dist, x, y, d);
        end
        prev_px   = x;
        prev_py   = y;
        prev_dist = d;
        if (fin) begin
            n += clip_edge(x, y, d, first_px, first_py, first_dist);
            emit_vertex(0, 0, KIND_END);
            n++;
            poly_open  = 1'b0;
            poly_count = '0;
        end
        if (n > 0) begin
            clipped_q[clipped_q.size() - 1].run_end = 1'b1;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return COORD_W'(v);
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(negedge aclk) begin
        m_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (clipped_q.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual x=%0h y=%0h kind=%0d",
                         $time, m_out_x, m_out_y, m_kind);
                mismatches++;
            end else begin
                want = clipped_q.pop_front();
                compare_field("out_x", want.x, m_out_x);
                compare_field("out_y", want.y, m_out_y);
                compare_field("kind", 32'(want.kind), 32'(m_kind));
                compare_field("vertex_count", 32'(want.count), 32'(m_vertex_count));
                compare_field("run_end", 32'(want.run_end), 32'(m_run_end));
            end
        end
    end

    // stimulus tasks start and end just after a falling edge
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y, input logic fin);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_vertex_x     <= x;
        s_vertex_y     <= y;
        s_final_vertex <= fin;
        do @(posedge aclk); while (!s_ready);
        clip_vertex(x, y, fin);
        vertices_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        while (clipped_q.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            CFG_NORMAL_X: begin
                plane_nx = value[NORM_W-1:0];
                mask     = 32'h0000FFFF;
            end
            CFG_NORMAL_Y: begin
                plane_ny = value[NORM_W-1:0];
                mask     = 32'h0000FFFF;
            end
            CFG_PLANE_OFFSET: begin
                plane_off = value;
                mask      = 32'hFFFFFFFF;
            end
            default: begin
                plane_flip = value[0];
                mask       = 32'h00000001;
            end
        endcase
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, idx, value & mask, prdata & mask);
            mismatches++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_plane(input logic signed [NORM_W-1:0] nx,
                             input logic signed [NORM_W-1:0] ny,
                             input logic signed [COORD_W-1:0] off, input logic flip);
        wait_idle(SETTLE);
        write_reg(CFG_NORMAL_X, 32'(nx));
        write_reg(CFG_NORMAL_Y, 32'(ny));
        write_reg(CFG_PLANE_OFFSET, off);
        write_reg(CFG_KEEP_OPPOSITE, 32'(flip));
    endtask

    task automatic random_plane();
        real                       phi;
        logic signed [NORM_W-1:0]  nx, ny;
        logic signed [COORD_W-1:0] off;
        if ($urandom_range(3) == 0) begin
            nx  = NORM_W'($urandom_range(32768) - 16384);
            ny  = NORM_W'($urandom_range(32768) - 16384);
            off = $urandom;
        end else begin
            phi = $urandom_range(62831) / 10000.0;
            nx  = NORM_W'($rtoi(16384.0 * $cos(phi)));
            ny  = NORM_W'($rtoi(16384.0 * $sin(phi)));
            off = $urandom_range(1 << 30) - (1 << 29);
        end
        set_plane(nx, ny, off, 1'($urandom_range(1)));
    endtask

    // convex polygon centered near the current plane so that edges cross it
    task automatic convex_polygon();
        int     n;
        longint r, j, sft, cx, cy;
        real    th0, th;
        n   = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        r   = $urandom_range(1, 1 << $urandom_range(4, 27));
        sft = longint'($urandom_range(1 << 29)) - (1 << 28);
        j   = longint'($urandom_range(3 * r)) - (3 * r) / 2;
        cx  = ((longint'(plane_off) * plane_nx) >>> 14) - ((sft * plane_ny) >>> 14)
              + ((j * plane_nx) >>> 14);
        cy  = ((longint'(plane_off) * plane_ny) >>> 14) + ((sft * plane_nx) >>> 14)
              + ((j * plane_ny) >>> 14);
        th0 = $urandom_range(62831) / 10000.0;
        for (int k = 0; k < n; k++) begin
            th = th0 + 6.2831853 * k / n;
            send_vertex(to_coord(cx + $rtoi(r * $cos(th))), to_coord(cy + $rtoi(r * $sin(th))),
                        k == n - 1);
        end
    endtask

    task automatic scattered_polygon();
        int                        n;
        logic signed [COORD_W-1:0] x, y;
        n = $urandom_range(1, 6);
        x = $urandom;
        y = $urandom;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(1) == 0) begin
                x = $urandom;
                y = $urandom;
            end
            send_vertex(x, y, k == n - 1);
        end
    endtask

    task automatic test_default_plane();
        send_vertex(-ONE, 5 * ONE, 1'b1);
        send_vertex(3 * ONE, 0, 1'b1);
        send_vertex(-2 * ONE, 0, 1'b0);
        send_vertex(2 * ONE, 2 * ONE, 1'b0);
        send_vertex(2 * ONE, -2 * ONE, 1'b1);
        // two vertices lying on the plane
        send_vertex(0, -ONE, 1'b0);
        send_vertex(0, ONE, 1'b0);
        send_vertex(-ONE, 0, 1'b1);
    endtask

    task automatic test_coordinate_extremes();
        set_plane(-16'sd16384, 16'sd16384, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh80000000, 32'sh80000000, 1'b1);
        set_plane(16'sd16384, -16'sd16384, 32'sh80000000, 1'b1);
        send_vertex(32'sh7FFFFFFF, 0, 1'b0);
        send_vertex(32'sh80000000, -32'sd1, 1'b0);
        send_vertex(0, 32'sh80000000, 1'b1);
    endtask

    task automatic test_plane_change_mid_polygon();
        set_plane(0, -16'sd16384, 0, 1'b0);
        send_vertex(ONE, ONE, 1'b0);
        send_vertex(ONE, -ONE, 1'b0);
        wait_idle(SETTLE);
        write_reg(CFG_KEEP_OPPOSITE, 32'd1);
        send_vertex(-ONE, 2 * ONE, 1'b1);
    endtask

    task automatic test_count_saturation();
        set_plane(16'sd16384, 0, 0, 1'b0);
        for (int k = 0; k < 130; k++) begin
            send_vertex(-(k + 1) * ONE, $urandom, k == 129);
        end
    endtask

    task automatic test_random_polygons(input int unsigned n_items);
        int unsigned target;
        target = vertices_sent + n_items;
        random_plane();
        while (vertices_sent < target) begin
            if ($urandom_range(99) < 30) begin
                random_plane();
            end
            if ($urandom_range(99) < 80) begin
                convex_polygon();
            end else begin
                scattered_polygon();
            end
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_default_plane();
        test_coordinate_extremes();
        test_plane_change_mid_polygon();
        test_count_saturation();
        test_random_polygons(20);
        send_idle_pct = 65;
        recv_idle_pct = 20;
        test_random_polygons(20);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_polygons(20);
        wait_idle(60);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/hpc_pkg.sv
src/hpc_cfg_regs.sv
src/hpc_mul.sv
src/hpc_div.sv
src/polygon_half_plane_clipper_top.sv
src/hpc_checker.sv
test/tb.sv
